@@ hdl/two_bone_elbow_position_assert.svh @@
// Assertion macros shared by the elbow position block.
`ifndef TWO_BONE_ELBOW_POSITION_ASSERT_SVH
`define TWO_BONE_ELBOW_POSITION_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define TBEP_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled during reset.
`define TBEP_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/tbep_pkg.sv @@
`default_nettype none
package tbep_pkg;

  // Unit vectors, cosine and sine are Q2.30.
  localparam int UNIT_BITS = 30;
  localparam int SQ_LAT    = 32;
  localparam int DIV_LAT   = UNIT_BITS;

  // Shortest orthogonal pole component that still counts (2^-10 in Q2.30).
  localparam logic [33:0] POLE_MIN = 34'd1048576;

  localparam logic [1:0] ST_NORMAL = 2'd0;
  localparam logic [1:0] ST_NEAR   = 2'd1;
  localparam logic [1:0] ST_POLE   = 2'd2;

  // A vector split into sign, pre-shift and scaled magnitudes.
  typedef struct packed {
    logic [2:0]       neg;
    logic [1:0]       k;
    logic [2:0][30:0] sc;
  } vprep_t;

  typedef struct packed {
    logic [2:0][31:0] sh;
    logic [30:0]      u;
    logic [30:0]      l;
    vprep_t           dp;
    vprep_t           pp;
  } ctx_a_t;

  typedef struct packed {
    ctx_a_t      a;
    logic [31:0] dlen;
    logic [31:0] plen;
    logic        near;
  } ctx_b_t;

  typedef struct packed {
    logic [2:0][31:0] sh;
    logic [30:0]      u;
    logic             near;
    logic [2:0]       dneg;
    logic [2:0]       pneg;
    logic             c_full;
    logic             c_neg;
    logic             c_sgn;
  } ctx_c_t;

  typedef struct packed {
    logic [2:0][31:0] sh;
    logic [30:0]      u;
    logic             near;
    logic [31:0]      c;
    logic [2:0][31:0] td;
  } ctx_d_t;

  typedef struct packed {
    ctx_d_t d;
    vprep_t qp;
  } ctx_e_t;

  typedef struct packed {
    ctx_d_t      d;
    logic [30:0] s;
    logic [2:0]  qneg;
    logic        pole_bad;
  } ctx_f_t;

endpackage
`default_nettype wire

@@ hdl/tbep_sqrt.sv @@
`default_nettype none
// Pipelined integer square root, one result bit per stage.
module tbep_sqrt import tbep_pkg::*; (
  input  wire logic        clk,
  input  wire logic        en,
  input  wire logic [63:0] radicand,
  output logic [31:0]      root
);

  logic [63:0] rem_r [SQ_LAT];
  logic [63:0] res_r [SQ_LAT];

  for (genvar j = 0; j < SQ_LAT; j++) begin : g_st
    localparam logic [63:0] BITV = 64'd1 << (62 - 2 * j);
    logic [63:0] v_in, r_in, trial, rem_nxt, res_nxt;

    if (j == 0) begin : g_first
      assign v_in = radicand;
      assign r_in = '0;
    end else begin : g_next
      assign v_in = rem_r[j-1];
      assign r_in = res_r[j-1];
    end

    always_comb begin
      trial = r_in + BITV;
      if (v_in >= trial) begin
        rem_nxt = v_in - trial;
        res_nxt = (r_in >> 1) + BITV;
      end else begin
        rem_nxt = v_in;
        res_nxt = r_in >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[j] <= rem_nxt;
        res_r[j] <= res_nxt;
      end
    end
  end

  assign root = res_r[SQ_LAT-1][31:0];

endmodule
`default_nettype wire

@@ hdl/tbep_div.sv @@
`default_nettype none
// Pipelined fractional divider: floor(num * 2^30 / den) for num < den,
// 2^30 when num >= den and zero when den is zero. One quotient bit per stage.
module tbep_div import tbep_pkg::*; #(
  parameter int W = 32
) (
  input  wire logic               clk,
  input  wire logic               en,
  input  wire logic [W-1:0]       num,
  input  wire logic [W-1:0]       den,
  output logic [UNIT_BITS:0]      quot
);

  logic [W-1:0]         rem_r  [DIV_LAT];
  logic [W-1:0]         den_r  [DIV_LAT];
  logic [UNIT_BITS-1:0] q_r    [DIV_LAT];
  logic                 zero_r [DIV_LAT];
  logic                 full_r [DIV_LAT];

  for (genvar j = 0; j < DIV_LAT; j++) begin : g_st
    logic [W-1:0]         rem_in, den_in, rem_nxt;
    logic [UNIT_BITS-1:0] q_in, q_nxt;
    logic                 zero_in, full_in;
    logic [W:0]           t;
    logic                 ge;

    if (j == 0) begin : g_first
      assign rem_in  = num;
      assign den_in  = den;
      assign q_in    = '0;
      assign zero_in = (den == '0);
      assign full_in = (num >= den);
    end else begin : g_next
      assign rem_in  = rem_r[j-1];
      assign den_in  = den_r[j-1];
      assign q_in    = q_r[j-1];
      assign zero_in = zero_r[j-1];
      assign full_in = full_r[j-1];
    end

    always_comb begin
      t  = {rem_in, 1'b0};
      ge = (t >= {1'b0, den_in});
      rem_nxt = ge ? W'(t - {1'b0, den_in}) : t[W-1:0];
      q_nxt   = {q_in[UNIT_BITS-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[j]  <= rem_nxt;
        den_r[j]  <= den_in;
        q_r[j]    <= q_nxt;
        zero_r[j] <= zero_in;
        full_r[j] <= full_in;
      end
    end
  end

  assign quot = zero_r[DIV_LAT-1] ? '0 :
                full_r[DIV_LAT-1] ? (UNIT_BITS+1)'(1) << UNIT_BITS :
                {1'b0, q_r[DIV_LAT-1]};

endmodule
`default_nettype wire

@@ hdl/two_bone_elbow_position.sv @@
// Throughput: one item per cycle; the whole pipeline moves together and only
// halts when a finished result is stalled at the output and the last stage is full.
// The rate is set by the pipelined square root and divider units (one bit per stage).
// Reset (rst_n low, synchronous) clears only the valid bits; no payload is cleared.
`default_nettype none
`include "two_bone_elbow_position_assert.svh"
module two_bone_elbow_position import tbep_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic signed [31:0] in_shoulder_x,
  input  wire logic signed [31:0] in_shoulder_y,
  input  wire logic signed [31:0] in_shoulder_z,
  input  wire logic signed [31:0] in_target_x,
  input  wire logic signed [31:0] in_target_y,
  input  wire logic signed [31:0] in_target_z,
  input  wire logic signed [31:0] in_pole_x,
  input  wire logic signed [31:0] in_pole_y,
  input  wire logic signed [31:0] in_pole_z,
  input  wire logic        [30:0] in_upper_len,
  input  wire logic        [30:0] in_lower_len,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [31:0]      out_elbow_x,
  output logic signed [31:0]      out_elbow_y,
  output logic signed [31:0]      out_elbow_z,
  output logic        [1:0]       out_status
);

  // The epsilon of 0.001 in Q.F, rounded, never below one LSB.
  localparam int EPS_CALC = ((1 << FRAC_BITS) + 500) / 1000;
  localparam int EPS_RAW  = (EPS_CALC > 0) ? EPS_CALC : 1;
  localparam logic [34:0] EPS_V = 35'(EPS_RAW);

  localparam int NST = 4 + SQ_LAT + 3 + DIV_LAT + 8 + SQ_LAT + 1 + DIV_LAT + 5;

  localparam logic signed [31:0] C_ONE   = 32'sh4000_0000;
  localparam logic        [63:0] ONE_SQ  = 64'h1000_0000_0000_0000;
  localparam logic signed [65:0] HALF_UL = 66'sd536870912;
  localparam logic signed [35:0] SAT_HI  = 36'sd2147483647;
  localparam logic signed [35:0] SAT_LO  = -36'sd2147483648;

  // Splits a vector into sign, a pre-shift of up to two bits and the
  // shifted magnitudes, so that the sum of squares stays within 64 bits.
  function automatic vprep_t prep_vec(input logic [2:0][33:0] v);
    logic [2:0][33:0] m;
    logic [2:0][32:0] a;
    logic             big1, big2;
    vprep_t           p;
    big1 = 1'b0;
    big2 = 1'b0;
    for (int i = 0; i < 3; i++) begin
      m[i] = v[i][33] ? (34'd0 - v[i]) : v[i];
      a[i] = m[i][32:0];
      big2 = big2 | a[i][32];
      big1 = big1 | a[i][31];
      p.neg[i] = v[i][33];
    end
    p.k = big2 ? 2'd2 : (big1 ? 2'd1 : 2'd0);
    for (int i = 0; i < 3; i++) begin
      p.sc[i] = 31'(a[i] >> p.k);
    end
    return p;
  endfunction

  function automatic logic [31:0] sat32(input logic signed [35:0] x);
    logic [31:0] r;
    if (x > SAT_HI) r = 32'h7FFF_FFFF;
    else if (x < SAT_LO) r = 32'h8000_0000;
    else r = x[31:0];
    return r;
  endfunction

  // Pipeline control. Every stage advances together; the pipe holds only
  // while a result sits stalled in the output register.
  logic           adv;
  logic [NST-1:0] vld_r;

  assign adv       = !vld_r[NST-1] || !out_stall;
  assign in_stall  = !adv;
  assign out_valid = vld_r[NST-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NST-2:0], in_valid};
    end
  end

  // ---------------------------------------------------------------------
  // Front end: difference vectors, pre-shift, squares and their sums.
  // ---------------------------------------------------------------------
  logic [2:0][33:0] dv_r, pv_r;
  logic [2:0][31:0] sh_s1_r;
  logic [30:0]      u_s1_r, l_s1_r;
  ctx_a_t           ctxa_s2_r, ctxa_s3_r, ctxa_s4_r;
  logic [2:0][61:0] dsq_r, psq_r;
  logic [63:0]      dsum_r, psum_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      dv_r[0] <= 34'(in_target_x) - 34'(in_shoulder_x);
      dv_r[1] <= 34'(in_target_y) - 34'(in_shoulder_y);
      dv_r[2] <= 34'(in_target_z) - 34'(in_shoulder_z);
      pv_r[0] <= 34'(in_pole_x) - 34'(in_shoulder_x);
      pv_r[1] <= 34'(in_pole_y) - 34'(in_shoulder_y);
      pv_r[2] <= 34'(in_pole_z) - 34'(in_shoulder_z);
      sh_s1_r <= {in_shoulder_z, in_shoulder_y, in_shoulder_x};
      u_s1_r  <= in_upper_len;
      l_s1_r  <= in_lower_len;

      ctxa_s2_r.sh <= sh_s1_r;
      ctxa_s2_r.u  <= u_s1_r;
      ctxa_s2_r.l  <= l_s1_r;
      ctxa_s2_r.dp <= prep_vec(dv_r);
      ctxa_s2_r.pp <= prep_vec(pv_r);

      ctxa_s3_r <= ctxa_s2_r;
      for (int i = 0; i < 3; i++) begin
        dsq_r[i] <= ctxa_s2_r.dp.sc[i] * ctxa_s2_r.dp.sc[i];
        psq_r[i] <= ctxa_s2_r.pp.sc[i] * ctxa_s2_r.pp.sc[i];
      end

      ctxa_s4_r <= ctxa_s3_r;
      dsum_r <= 64'(dsq_r[0]) + 64'(dsq_r[1]) + 64'(dsq_r[2]);
      psum_r <= 64'(psq_r[0]) + 64'(psq_r[1]) + 64'(psq_r[2]);
    end
  end

  // Lengths of the target and pole directions.
  logic [31:0] dlen, plen;
  ctx_a_t      ctxa_dl_r [SQ_LAT];

  tbep_sqrt u_sqrt_d (.clk(clk), .en(adv), .radicand(dsum_r), .root(dlen));
  tbep_sqrt u_sqrt_p (.clk(clk), .en(adv), .radicand(psum_r), .root(plen));

  always_ff @(posedge clk) begin
    if (adv) begin
      ctxa_dl_r[0] <= ctxa_s4_r;
      for (int i = 1; i < SQ_LAT; i++) ctxa_dl_r[i] <= ctxa_dl_r[i-1];
    end
  end

  // ---------------------------------------------------------------------
  // Reach clamp and the law of cosines terms.
  // ---------------------------------------------------------------------
  ctx_a_t             ca;
  logic [33:0]        tdist;
  logic [30:0]        absdiff;
  logic signed [34:0] minr, maxr, dclamp_nxt;

  assign ca = ctxa_dl_r[SQ_LAT-1];

  always_comb begin
    tdist      = 34'(dlen) << ca.dp.k;
    absdiff    = (ca.u > ca.l) ? (ca.u - ca.l) : (ca.l - ca.u);
    minr       = $signed({4'd0, absdiff}) + $signed(EPS_V);
    maxr       = $signed({4'd0, ca.u}) + $signed({4'd0, ca.l}) - $signed(EPS_V);
    dclamp_nxt = $signed({1'b0, tdist});
    if (dclamp_nxt < minr) dclamp_nxt = minr;
    if (dclamp_nxt > maxr) dclamp_nxt = maxr;
  end

  ctx_b_t             ctxb_r [3];
  logic signed [34:0] distc_r;
  logic [61:0]        uu2_r, dd2_r, ll2_r, ud_r;
  logic               c_one_r;
  logic [62:0]        cnum_r, cden_r;
  logic               c_full_r, c_neg_r, c_sgn_r;

  // Large reach halves u, l and d so that every square fits.
  logic               big;
  logic [30:0]        uu, ll, dd;
  logic signed [64:0] num65, den65;
  logic [64:0]        nmag;

  always_comb begin
    big = !distc_r[34] && (distc_r[33:31] != 3'd0);
    uu  = big ? {1'b0, ctxb_r[0].a.u[30:1]} : ctxb_r[0].a.u;
    ll  = big ? {1'b0, ctxb_r[0].a.l[30:1]} : ctxb_r[0].a.l;
    dd  = big ? distc_r[31:1] : distc_r[30:0];
    num65 = $signed({3'd0, uu2_r}) + $signed({3'd0, dd2_r}) - $signed({3'd0, ll2_r});
    den65 = $signed({2'd0, ud_r, 1'b0});
    nmag  = num65[64] ? 65'(-num65) : 65'(num65);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ctxb_r[0].a    <= ca;
      ctxb_r[0].dlen <= dlen;
      ctxb_r[0].plen <= plen;
      ctxb_r[0].near <= (tdist < EPS_V[33:0]);
      distc_r        <= dclamp_nxt;

      ctxb_r[1] <= ctxb_r[0];
      uu2_r     <= uu * uu;
      ll2_r     <= ll * ll;
      dd2_r     <= dd * dd;
      ud_r      <= uu * dd;
      c_one_r   <= (ctxb_r[0].a.u == '0) || distc_r[34] || (distc_r == '0);

      ctxb_r[2] <= ctxb_r[1];
      c_full_r  <= c_one_r || (den65 == '0) || (num65 >= den65);
      c_neg_r   <= (num65 <= -den65);
      c_sgn_r   <= num65[64];
      cnum_r    <= nmag[62:0];
      cden_r    <= den65[62:0];
    end
  end

  // ---------------------------------------------------------------------
  // Seven divisions in parallel: target unit vector, pole unit vector and
  // the cosine magnitude.
  // ---------------------------------------------------------------------
  logic [2:0][UNIT_BITS:0] tdq, pdq;
  logic [UNIT_BITS:0]      cq;

  for (genvar i = 0; i < 3; i++) begin : g_div_dp
    tbep_div #(.W(32)) u_div_t (
      .clk(clk), .en(adv), .num({1'b0, ctxb_r[2].a.dp.sc[i]}),
      .den(ctxb_r[2].dlen), .quot(tdq[i])
    );
    tbep_div #(.W(32)) u_div_p (
      .clk(clk), .en(adv), .num({1'b0, ctxb_r[2].a.pp.sc[i]}),
      .den(ctxb_r[2].plen), .quot(pdq[i])
    );
  end

  tbep_div #(.W(63)) u_div_c (
    .clk(clk), .en(adv), .num(cnum_r), .den(cden_r), .quot(cq)
  );

  ctx_c_t ctxc_dl_r [DIV_LAT];

  always_ff @(posedge clk) begin
    if (adv) begin
      ctxc_dl_r[0].sh     <= ctxb_r[2].a.sh;
      ctxc_dl_r[0].u      <= ctxb_r[2].a.u;
      ctxc_dl_r[0].near   <= ctxb_r[2].near;
      ctxc_dl_r[0].dneg   <= ctxb_r[2].a.dp.neg;
      ctxc_dl_r[0].pneg   <= ctxb_r[2].a.pp.neg;
      ctxc_dl_r[0].c_full <= c_full_r;
      ctxc_dl_r[0].c_neg  <= c_neg_r;
      ctxc_dl_r[0].c_sgn  <= c_sgn_r;
      for (int i = 1; i < DIV_LAT; i++) ctxc_dl_r[i] <= ctxc_dl_r[i-1];
    end
  end

  // ---------------------------------------------------------------------
  // Pole orthogonalization: dot product, projection removal, new length.
  // ---------------------------------------------------------------------
  ctx_c_t           cc_ctx;
  logic [31:0]      c_nxt, cqx;
  logic [2:0][31:0] td_nxt, pd_nxt;

  assign cc_ctx = ctxc_dl_r[DIV_LAT-1];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      td_nxt[i] = cc_ctx.dneg[i] ? (32'd0 - {1'b0, tdq[i]}) : {1'b0, tdq[i]};
      pd_nxt[i] = cc_ctx.pneg[i] ? (32'd0 - {1'b0, pdq[i]}) : {1'b0, pdq[i]};
    end
    cqx = {1'b0, cq};
    if (cc_ctx.c_full) c_nxt = C_ONE;
    else if (cc_ctx.c_neg) c_nxt = -C_ONE;
    else c_nxt = cc_ctx.c_sgn ? (32'd0 - cqx) : cqx;
  end

  ctx_d_t             ctxd_r  [8];
  logic [2:0][31:0]   pdl_r   [4];
  logic signed [63:0] pt_r    [3];
  logic [63:0]        cc_r;
  logic [63:0]        sradl_r [6];
  logic [33:0]        dot_r;
  logic signed [65:0] dt_r    [3];
  logic [2:0][33:0]   qv_r;
  vprep_t             qprep_r [3];
  logic [2:0][61:0]   qsq_r;
  logic [63:0]        qsum_r;
  logic signed [63:0] dsum3;

  assign dsum3 = pt_r[0] + pt_r[1] + pt_r[2];

  always_ff @(posedge clk) begin
    if (adv) begin
      ctxd_r[0].sh   <= cc_ctx.sh;
      ctxd_r[0].u    <= cc_ctx.u;
      ctxd_r[0].near <= cc_ctx.near;
      ctxd_r[0].c    <= c_nxt;
      ctxd_r[0].td   <= td_nxt;
      for (int i = 1; i < 8; i++) ctxd_r[i] <= ctxd_r[i-1];
      pdl_r[0] <= pd_nxt;
      for (int i = 1; i < 4; i++) pdl_r[i] <= pdl_r[i-1];

      for (int i = 0; i < 3; i++) begin
        pt_r[i] <= $signed(pdl_r[0][i]) * $signed(ctxd_r[0].td[i]);
      end
      cc_r <= $signed(ctxd_r[0].c) * $signed(ctxd_r[0].c);

      dot_r      <= 34'(dsum3 >>> UNIT_BITS);
      sradl_r[0] <= ONE_SQ - cc_r;
      for (int i = 1; i < 6; i++) sradl_r[i] <= sradl_r[i-1];

      for (int i = 0; i < 3; i++) begin
        dt_r[i] <= $signed(dot_r) * $signed(ctxd_r[2].td[i]);
      end

      for (int i = 0; i < 3; i++) begin
        qv_r[i] <= 34'($signed(pdl_r[3][i])) - 34'(dt_r[i] >>> UNIT_BITS);
      end

      qprep_r[0] <= prep_vec(qv_r);
      qprep_r[1] <= qprep_r[0];
      qprep_r[2] <= qprep_r[1];

      for (int i = 0; i < 3; i++) begin
        qsq_r[i] <= qprep_r[0].sc[i] * qprep_r[0].sc[i];
      end
      qsum_r <= 64'(qsq_r[0]) + 64'(qsq_r[1]) + 64'(qsq_r[2]);
    end
  end

  // Sine from 1 - c^2 and the length of the orthogonal pole part, side by side.
  logic [31:0] qlen, sroot;
  ctx_e_t      ctxe_dl_r [SQ_LAT];

  tbep_sqrt u_sqrt_q (.clk(clk), .en(adv), .radicand(qsum_r), .root(qlen));
  tbep_sqrt u_sqrt_s (.clk(clk), .en(adv), .radicand(sradl_r[5]), .root(sroot));

  always_ff @(posedge clk) begin
    if (adv) begin
      ctxe_dl_r[0].d  <= ctxd_r[7];
      ctxe_dl_r[0].qp <= qprep_r[2];
      for (int i = 1; i < SQ_LAT; i++) ctxe_dl_r[i] <= ctxe_dl_r[i-1];
    end
  end

  // A pole part shorter than 2^-10 (or a pole at the shoulder, which gives
  // a zero vector here) drops the pole term.
  ctx_e_t      ce;
  logic [33:0] qdist;
  ctx_e_t      ctxe_d1_r;
  logic [31:0] qlen_r;
  logic [30:0] s_r;
  logic        pole_bad_r;

  assign ce    = ctxe_dl_r[SQ_LAT-1];
  assign qdist = 34'(qlen) << ce.qp.k;

  always_ff @(posedge clk) begin
    if (adv) begin
      ctxe_d1_r  <= ce;
      qlen_r     <= qlen;
      s_r        <= sroot[30:0];
      pole_bad_r <= (qdist < POLE_MIN);
    end
  end

  logic [2:0][UNIT_BITS:0] qnq;

  for (genvar i = 0; i < 3; i++) begin : g_div_q
    tbep_div #(.W(32)) u_div_q (
      .clk(clk), .en(adv), .num({1'b0, ctxe_d1_r.qp.sc[i]}),
      .den(qlen_r), .quot(qnq[i])
    );
  end

  ctx_f_t ctxf_dl_r [DIV_LAT];

  always_ff @(posedge clk) begin
    if (adv) begin
      ctxf_dl_r[0].d        <= ctxe_d1_r.d;
      ctxf_dl_r[0].s        <= s_r;
      ctxf_dl_r[0].qneg     <= ctxe_d1_r.qp.neg;
      ctxf_dl_r[0].pole_bad <= pole_bad_r;
      for (int i = 1; i < DIV_LAT; i++) ctxf_dl_r[i] <= ctxf_dl_r[i-1];
    end
  end

  // ---------------------------------------------------------------------
  // Elbow: shoulder + u * (c * T + s * P), rounded and saturated.
  // ---------------------------------------------------------------------
  ctx_f_t             cf;
  ctx_f_t             ctxf_r [4];
  logic [2:0][31:0]   qn_nxt;
  logic [2:0][31:0]   qn_r;
  logic signed [63:0] ct_r [3];
  logic signed [63:0] sq_r [3];
  logic [2:0][33:0]   dir_r;
  logic signed [65:0] ul_r [3];
  logic signed [63:0] dsum [3];
  logic signed [35:0] off  [3];
  logic signed [35:0] pos  [3];
  logic [2:0][31:0]   el_nxt;
  logic [1:0]         st_nxt;
  logic signed [35:0] near_y;
  logic [31:0]        ex_r, ey_r, ez_r;
  logic [1:0]         st_r;

  assign cf = ctxf_dl_r[DIV_LAT-1];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (cf.pole_bad) qn_nxt[i] = '0;
      else qn_nxt[i] = cf.qneg[i] ? (32'd0 - {1'b0, qnq[i]}) : {1'b0, qnq[i]};
      dsum[i] = ct_r[i] + sq_r[i];
      off[i]  = 36'((ul_r[i] + HALF_UL) >>> UNIT_BITS);
      pos[i]  = 36'($signed(ctxf_r[3].d.sh[i])) + off[i];
      el_nxt[i] = sat32(pos[i]);
    end
    st_nxt = ctxf_r[3].pole_bad ? ST_POLE : ST_NORMAL;
    // A target at the shoulder points the upper bone straight up the y axis.
    near_y = 36'($signed(ctxf_r[3].d.sh[1])) + $signed({5'd0, ctxf_r[3].d.u});
    if (ctxf_r[3].d.near) begin
      el_nxt[0] = ctxf_r[3].d.sh[0];
      el_nxt[1] = sat32(near_y);
      el_nxt[2] = ctxf_r[3].d.sh[2];
      st_nxt    = ST_NEAR;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ctxf_r[0] <= cf;
      for (int i = 1; i < 4; i++) ctxf_r[i] <= ctxf_r[i-1];
      qn_r <= qn_nxt;
      for (int i = 0; i < 3; i++) begin
        ct_r[i]  <= $signed(ctxf_r[0].d.c) * $signed(ctxf_r[0].d.td[i]);
        sq_r[i]  <= $signed({1'b0, ctxf_r[0].s}) * $signed(qn_r[i]);
        dir_r[i] <= 34'(dsum[i] >>> UNIT_BITS);
        ul_r[i]  <= $signed({1'b0, ctxf_r[2].d.u}) * $signed(dir_r[i]);
      end
      ex_r <= el_nxt[0];
      ey_r <= el_nxt[1];
      ez_r <= el_nxt[2];
      st_r <= st_nxt;
    end
  end

  assign out_elbow_x = ex_r;
  assign out_elbow_y = ey_r;
  assign out_elbow_z = ez_r;
  assign out_status  = st_r;

  // The input side only ever waits on a blocked result.
  `TBEP_ASSERT_IMP(a_stall_cause, in_stall, out_valid && out_stall,
                   "input stalled while the output was free")
  // When the pipe moves, the item from the stage before the output arrives.
  `TBEP_ASSERT_NXT(a_pipe_advance, !in_stall, out_valid == $past(vld_r[NST-2]),
                   "output valid did not follow the pipeline")
  // Only the three defined status codes ever leave the block.
  `TBEP_ASSERT_IMP(a_status_code, out_valid,
                   out_status == ST_NORMAL || out_status == ST_NEAR || out_status == ST_POLE,
                   "undefined status code on a valid result")

endmodule
`default_nettype wire
